// ===== hdl/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

    // Fixed field widths of the block's ports
    localparam int PAGE_PORT_W = 16;
    localparam int SLOT_W      = 3;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Control of the frame compare unit
    typedef struct packed {
        logic clear;
        logic valid;
    } cmp_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lrupr_ram.sv =====
`default_nettype none

module lrupr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lrupr_cmp.sv =====
`default_nettype none

// Walks the resident frames one beat at a time: finds the first frame holding
// the key page and the frame with the oldest rank.
module lrupr_cmp #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lrupr_pkg::cmp_ctl_t     ctl,
    input  wire logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] idx,
    input  wire logic [PAGE_BITS-1:0]    key,
    input  wire logic [PAGE_BITS-1:0]    page,
    input  wire logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rank,
    output logic                         hit,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_idx,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] hit_rank,
    output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] old_idx,
    output logic [PAGE_BITS-1:0]         old_page
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic          hit_reg, hit_next;
    logic          found_reg, found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] hit_rank_reg, hit_rank_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [IW-1:0] old_rank_reg, old_rank_next;
    logic [PAGE_BITS-1:0] old_page_reg, old_page_next;

    always_comb
    begin
        hit_next      = hit_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        hit_rank_next = hit_rank_reg;
        old_idx_next  = old_idx_reg;
        old_rank_next = old_rank_reg;
        old_page_next = old_page_reg;
        if (ctl.clear)
        begin
            hit_next   = 1'b0;
            found_next = 1'b0;
        end
        else if (ctl.valid)
        begin
            // keep the first match only
            if (!hit_reg && page == key)
            begin
                hit_next      = 1'b1;
                hit_idx_next  = idx;
                hit_rank_next = rank;
            end
            if (!found_reg || rank > old_rank_reg)
            begin
                found_next    = 1'b1;
                old_idx_next  = idx;
                old_rank_next = rank;
                old_page_next = page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            hit_reg   <= hit_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        old_idx_reg  <= old_idx_next;
        old_rank_reg <= old_rank_next;
        old_page_reg <= old_page_next;
    end

    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_rank = hit_rank_reg;
    assign old_idx  = old_idx_reg;
    assign old_page = old_page_reg;

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
`default_nettype none

// LRU page replacement. Each input beat is one page reference; each produces
// exactly one result beat (fault, evicted page, frame slot, running fault
// total). Pages and recency ranks live in one single-port-read frame RAM, so
// a reference reads every occupied frame twice: a scan pass through a shared
// compare unit (hit search and oldest rank), then an aging pass that rewrites
// the ranks. The next reference is accepted only once this one's result is
// loaded, so a stalled output also holds off the input. The frame RAM needs
// no clearing after reset: the occupied count marks the valid frames.
// end_of_string empties the frames and the fault total once its result is
// loaded. frame_count is taken only while idle; 0 acts as 1 and values
// above MAX_FRAMES act as MAX_FRAMES.
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]         frame_count,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]   page_number,
    input  wire logic                                end_of_string,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     page_fault,
    output logic                                     evicted_valid,
    output logic [lrupr_pkg::PAGE_PORT_W-1:0]        evicted_page,
    output logic [lrupr_pkg::SLOT_W-1:0]             frame_slot,
    output logic [lrupr_pkg::COUNT_W-1:0]            fault_total
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int EW = PAGE_BITS + RW;
    localparam int PW = lrupr_pkg::PAGE_PORT_W;
    localparam int NW = lrupr_pkg::COUNT_W;

    lrupr_pkg::state_t state_reg, state_next;

    logic [lrupr_pkg::CFG_W-1:0] frame_count_reg;
    logic [PAGE_BITS-1:0]        page_reg, page_next;
    logic                        last_reg, last_next;
    logic [CW-1:0]               occ_reg, occ_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [CW-1:0]               ctr_reg, ctr_next;
    logic                        dv_reg;
    logic [IW-1:0]               didx_reg;
    logic [NW-1:0]               fault_cnt_reg, fault_cnt_next;
    logic [IW-1:0]               slot_reg, slot_next;
    logic                        inc_all_reg, inc_all_next;
    logic                        evict_reg, evict_next;
    logic [PW-1:0]               evpage_reg, evpage_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_fault_reg, out_fault_next;
    logic                        out_evict_reg, out_evict_next;
    logic [PW-1:0]               out_evpage_reg, out_evpage_next;
    logic [lrupr_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [NW-1:0]               out_total_reg, out_total_next;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [EW-1:0]               wr_data;
    logic                        rd_en;
    logic [EW-1:0]               rd_data;

    lrupr_pkg::cmp_ctl_t         cmp_ctl;
    logic                        cmp_hit;
    logic [IW-1:0]               cmp_hit_idx;
    logic [RW-1:0]               cmp_hit_rank;
    logic [IW-1:0]               cmp_old_idx;
    logic [PAGE_BITS-1:0]        cmp_old_page;

    logic [CW-1:0]               limit;
    logic [PAGE_BITS-1:0]        page_in;
    logic [PAGE_BITS-1:0]        rd_page;
    logic [RW-1:0]               rd_rank;
    logic [EW-1:0]               upd_entry;

    assign page_in = PAGE_BITS'(page_number);
    assign rd_page = rd_data[EW-1:RW];
    assign rd_rank = rd_data[RW-1:0];
    assign cfg_ready = (state_reg == lrupr_pkg::ST_IDLE);

    lrupr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FRAMES)
    ) u_frames (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ctr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    lrupr_cmp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cmp_ctl),
        .idx      (didx_reg),
        .key      (page_reg),
        .page     (rd_page),
        .rank     (rd_rank),
        .hit      (cmp_hit),
        .hit_idx  (cmp_hit_idx),
        .hit_rank (cmp_hit_rank),
        .old_idx  (cmp_old_idx),
        .old_page (cmp_old_page)
    );

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            limit = CW'(1);
        end
        else if (32'(frame_count_reg) > 32'(MAX_FRAMES))
        begin
            limit = CW'(MAX_FRAMES);
        end
        else
        begin
            limit = CW'(frame_count_reg);
        end
    end

    // Aging pass: the referenced slot becomes newest, others age as needed
    always_comb
    begin
        if (didx_reg == slot_reg)
        begin
            upd_entry = {page_reg, RW'(0)};
        end
        else if (inc_all_reg || rd_rank < cmp_hit_rank)
        begin
            upd_entry = {rd_page, rd_rank + RW'(1)};
        end
        else
        begin
            upd_entry = rd_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        page_next       = page_reg;
        last_next       = last_reg;
        occ_next        = occ_reg;
        n_next          = n_reg;
        ctr_next        = ctr_reg;
        fault_cnt_next  = fault_cnt_reg;
        slot_next       = slot_reg;
        inc_all_next    = inc_all_reg;
        evict_next      = evict_reg;
        evpage_next     = evpage_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_fault_next  = out_fault_reg;
        out_evict_next  = out_evict_reg;
        out_evpage_next = out_evpage_reg;
        out_slot_next   = out_slot_reg;
        out_total_next  = out_total_reg;
        in_stall        = 1'b1;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = didx_reg;
        wr_data         = upd_entry;
        cmp_ctl         = '{clear: 1'b0, valid: 1'b0};

        unique case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    page_next     = page_in;
                    last_next     = end_of_string;
                    n_next        = occ_reg;
                    ctr_next      = '0;
                    cmp_ctl.clear = 1'b1;
                    state_next    = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN:
            begin
                cmp_ctl.valid = dv_reg;
                if (ctr_reg != n_reg)
                begin
                    rd_en    = 1'b1;
                    ctr_next = ctr_reg + CW'(1);
                end
                else
                begin
                    state_next = lrupr_pkg::ST_DECIDE;
                end
            end
            lrupr_pkg::ST_DECIDE:
            begin
                inc_all_next = !cmp_hit;
                ctr_next     = '0;
                evict_next   = 1'b0;
                evpage_next  = '0;
                if (cmp_hit)
                begin
                    slot_next = cmp_hit_idx;
                end
                else
                begin
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_next = fault_cnt_reg + NW'(1);
                    end
                    if (occ_reg < limit)
                    begin
                        // fill the next free frame
                        slot_next = occ_reg[IW-1:0];
                        wr_en     = 1'b1;
                        wr_addr   = occ_reg[IW-1:0];
                        wr_data   = {page_reg, RW'(0)};
                        occ_next  = occ_reg + CW'(1);
                    end
                    else
                    begin
                        slot_next   = cmp_old_idx;
                        evict_next  = 1'b1;
                        evpage_next = PW'(cmp_old_page);
                    end
                end
                state_next = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE:
            begin
                wr_en = dv_reg;
                if (ctr_reg != n_reg)
                begin
                    rd_en    = 1'b1;
                    ctr_next = ctr_reg + CW'(1);
                end
                else
                begin
                    state_next = lrupr_pkg::ST_FINISH;
                end
            end
            lrupr_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_fault_next  = inc_all_reg;
                    out_evict_next  = evict_reg;
                    out_evpage_next = evpage_reg;
                    out_slot_next   = lrupr_pkg::SLOT_W'(slot_reg);
                    out_total_next  = fault_cnt_reg;
                    if (last_reg)
                    begin
                        occ_next       = '0;
                        fault_cnt_next = '0;
                    end
                    state_next = lrupr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrupr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lrupr_pkg::CFG_RESET;
            occ_reg         <= '0;
            n_reg           <= '0;
            ctr_reg         <= '0;
            dv_reg          <= 1'b0;
            fault_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frame_count_reg <= frame_count;
            end
            occ_reg       <= occ_next;
            n_reg         <= n_next;
            ctr_reg       <= ctr_next;
            dv_reg        <= rd_en;
            fault_cnt_reg <= fault_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        last_reg       <= last_next;
        didx_reg       <= ctr_reg[IW-1:0];
        slot_reg       <= slot_next;
        inc_all_reg    <= inc_all_next;
        evict_reg      <= evict_next;
        evpage_reg     <= evpage_next;
        out_fault_reg  <= out_fault_next;
        out_evict_reg  <= out_evict_next;
        out_evpage_reg <= out_evpage_next;
        out_slot_reg   <= out_slot_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid     = out_valid_reg;
    assign page_fault    = out_fault_reg;
    assign evicted_valid = out_evict_reg;
    assign evicted_page  = out_evpage_reg;
    assign frame_slot    = out_slot_reg;
    assign fault_total   = out_total_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(MAX_FRAMES))
        else $error("occupied frame count beyond capacity");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrupr_pkg::ST_DECIDE) |-> !dv_reg)
        else $error("frame read still in flight at decision");

    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_evict_reg || out_fault_reg))
        else $error("eviction reported without a fault");

    a_evict_page: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_evict_reg) |-> (out_evpage_reg == '0))
        else $error("evicted page nonzero with no eviction");

endmodule

`default_nettype wire

// ===== sim/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_tb;

    localparam int FRAMES    = 8;
    localparam int PAGES_W   = 16;
    localparam int PHASE_LEN = 150;
    localparam int HOLD_LEN  = 400;
    localparam int PORT_W    = lrupr_pkg::PAGE_PORT_W;
    localparam int SLOT_W    = lrupr_pkg::SLOT_W;
    localparam int COUNT_W   = lrupr_pkg::COUNT_W;
    localparam int CFG_W     = lrupr_pkg::CFG_W;

    typedef struct packed {
        logic                   fault;
        logic                   evicted;
        logic [PORT_W-1:0]      victim;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_W-1:0]     total;
    } lru_result_t;

    typedef struct packed {
        logic [PORT_W-1:0]      page;
        logic                   eos;
        logic                   typed;
        lru_result_t            want;
    } ref_row_t;

    localparam lru_result_t NO_RES = '0;

    localparam int DIR_ROWS = 18;
    localparam ref_row_t DIRECTED [DIR_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd0, 16'd1}},
        '{16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd1, 16'd2}},
        '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 3'd0, 16'd2}},
        '{16'h0002, 1'b0, 1'b0, NO_RES},
        '{16'h0003, 1'b0, 1'b0, NO_RES},
        '{16'h0004, 1'b0, 1'b0, NO_RES},
        '{16'h0005, 1'b0, 1'b0, NO_RES},
        '{16'h0006, 1'b0, 1'b0, NO_RES},
        '{16'h0007, 1'b0, 1'b0, NO_RES},
        '{16'h8000, 1'b0, 1'b0, NO_RES},
        '{16'hFFFF, 1'b0, 1'b0, NO_RES},
        '{16'h0005, 1'b0, 1'b0, NO_RES},
        '{16'h0005, 1'b0, 1'b0, NO_RES},
        '{16'hAAAA, 1'b0, 1'b0, NO_RES},
        '{16'h5555, 1'b1, 1'b0, NO_RES},
        '{16'h5555, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd0, 16'd1}},
        '{16'h5555, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000, 3'd0, 16'd1}},
        '{16'h0001, 1'b1, 1'b1, '{1'b1, 1'b0, 16'h0000, 3'd0, 16'd1}}
    };

    // Mid-string changes are intended: phases need not end on a string boundary
    localparam int PHASES = 13;
    localparam logic [CFG_W-1:0] PHASE_COUNTS [PHASES] = '{
        4'd1, 4'd0, 4'd15, 4'd4, 4'd9, 4'd2, 4'd8, 4'd3, 4'd6, 4'd5, 4'd7, 4'd10, 4'd8
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       frame_count   = lrupr_pkg::CFG_RESET;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [PORT_W-1:0]      page_number   = '0;
    logic                   end_of_string = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic                   page_fault;
    logic                   evicted_valid;
    logic [PORT_W-1:0]      evicted_page;
    logic [SLOT_W-1:0]      frame_slot;
    logic [COUNT_W-1:0]     fault_total;

    // Shadow of the frame table
    logic [PORT_W-1:0]      shadow_page [FRAMES];
    logic                   shadow_valid [FRAMES];
    logic [SLOT_W-1:0]      shadow_rank [FRAMES];
    int                     shadow_occupied;
    logic [COUNT_W-1:0]     shadow_faults;
    logic [CFG_W-1:0]       shadow_count;

    lru_result_t awaited_outcomes [$];
    int          errors  = 0;
    bit          calm    = 1'b0;
    bit          hold_go = 1'b0;

    lru_page_replacement #(
        .MAX_FRAMES (FRAMES),
        .PAGE_BITS  (PAGES_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frame_count   (frame_count),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .page_fault    (page_fault),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .frame_slot    (frame_slot),
        .fault_total   (fault_total)
    );

    always #10 clk = ~clk;

    function automatic void clear_shadow();
        for (int i = 0; i < FRAMES; i++)
        begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_occupied = 0;
        shadow_faults   = '0;
    endfunction

    // Age every resident frame below limit, then make slot the newest
    function automatic void age_frames(input int slot, input int limit);
        for (int i = 0; i < FRAMES; i++)
            if (shadow_valid[i] && i != slot && int'(shadow_rank[i]) < limit)
                shadow_rank[i]++;
        shadow_rank[slot] = '0;
    endfunction

    function automatic lru_result_t predict_reference(input logic [PORT_W-1:0] page,
                                                      input logic eos);
        lru_result_t r;
        int          lim;
        int          slot;
        bit          hit;
        bit          found;
        logic [SLOT_W-1:0] oldest;
        r    = '0;
        lim  = int'(shadow_count);
        if (lim < 1)
            lim = 1;
        if (lim > FRAMES)
            lim = FRAMES;
        hit  = 1'b0;
        slot = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!hit && shadow_valid[i] && shadow_page[i] == page)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (hit)
            age_frames(slot, int'(shadow_rank[slot]));
        else
        begin
            r.fault = 1'b1;
            if (shadow_faults != '1)
                shadow_faults++;
            if (shadow_occupied < lim)
            begin
                slot = shadow_occupied;
                shadow_valid[slot] = 1'b1;
                shadow_page[slot]  = page;
                age_frames(slot, FRAMES);
                shadow_occupied++;
            end
            else
            begin
                // Evict the oldest of all resident pages, even past the count
                found  = 1'b0;
                oldest = '0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (shadow_valid[i] && (!found || shadow_rank[i] > oldest))
                    begin
                        oldest = shadow_rank[i];
                        slot   = i;
                        found  = 1'b1;
                    end
                end
                r.evicted = found;
                if (found)
                    r.victim = shadow_page[slot];
                shadow_valid[slot] = 1'b1;
                shadow_page[slot]  = page;
                age_frames(slot, FRAMES);
            end
        end
        r.slot  = slot[SLOT_W-1:0];
        r.total = shadow_faults;
        if (eos)
            clear_shadow();
        return r;
    endfunction

    task automatic send_reference(input logic [PORT_W-1:0] page, input logic eos,
                                  input logic typed, input lru_result_t want);
        lru_result_t predicted;
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        page_number   <= page;
        end_of_string <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_reference(page, eos);
        awaited_outcomes = {awaited_outcomes, (typed ? want : predicted)};
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid   <= 1'b1;
        frame_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_count  = value;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        lru_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                errors++;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("page_fault", 16'(want.fault), 16'(page_fault));
                check_field("evicted_valid", 16'(want.evicted), 16'(evicted_valid));
                check_field("evicted_page", want.victim, evicted_page);
                check_field("frame_slot", 16'(want.slot), 16'(frame_slot));
                check_field("fault_total", want.total, fault_total);
            end
        end
    end

    initial
    begin : result_stall
        int k;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                // Hold off the output long enough for the input to back up
                hold_go = 1'b0;
                out_stall <= 1'b1;
                for (k = 0; k < HOLD_LEN; k++)
                    @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(99) < 7);
        end
    end

    initial
    begin : watchdog
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                     ph;
        int                     n;
        int                     str_left;
        int                     pool_n;
        bit                     noisy;
        logic [PORT_W-1:0]      pool [12];
        logic [PORT_W-1:0]      page;
        str_left = 0;
        pool_n   = 1;
        noisy    = 1'b0;
        clear_shadow();
        shadow_count = lrupr_pkg::CFG_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++)
            send_reference(DIRECTED[n].page, DIRECTED[n].eos, DIRECTED[n].typed,
                           DIRECTED[n].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_frame_count(PHASE_COUNTS[ph]);
            calm = (ph == 6);
            if (ph == 3)
                hold_go = 1'b1;
            for (n = 0; n < PHASE_LEN; n++)
            begin
                if (str_left == 0)
                begin
                    // Open a new string over a small working set
                    str_left = $urandom_range(1, 40);
                    pool_n   = $urandom_range(1, 12);
                    for (int i = 0; i < 12; i++)
                        pool[i] = PORT_W'($urandom);
                    noisy = ($urandom_range(9) == 0);
                end
                if (noisy || $urandom_range(9) == 0)
                    page = PORT_W'($urandom);
                else
                    page = pool[$urandom_range(pool_n - 1)];
                str_left--;
                send_reference(page, str_left == 0, 1'b0, NO_RES);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (4 * FRAMES + 10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
